>>> hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine execute package
// Shared sizes, status codes, primitive codes and the sequencer state type.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int WORD_W      = 32;
    localparam int BODY_W      = 30;
    localparam int STATUS_W    = 3;
    localparam int OUT_W       = 40;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    localparam logic [BODY_W-1:0] PRIM_HALT = 30'd0;
    localparam logic [BODY_W-1:0] PRIM_ADD  = 30'd1;
    localparam logic [BODY_W-1:0] PRIM_SUB  = 30'd2;
    localparam logic [BODY_W-1:0] PRIM_MUL  = 30'd3;
    localparam logic [BODY_W-1:0] PRIM_DIV  = 30'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

>>> hdl/sme_stack_ram.sv
// ----------------------------------------------------------------------------
// Stack memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sme_stack_ram
    import sme_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [PTR_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [PTR_W-1:0]  rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/sme_div.sv
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sme_div
    import sme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quot_reg, quot_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_shift = {rem_reg, quot_reg[WORD_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quot_next = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end else if (busy_reg) begin
            if (!diff[WORD_W]) begin
                rem_next  = diff[WORD_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift[WORD_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quot_reg + 1'b1) : quot_reg;

endmodule

>>> hdl/stack_machine_execute_unit.sv
// Each item is accepted in S_IDLE and decoded in S_DECODE. Push, halt, ignored, underflow,
// overflow and unknown-primitive items then go to S_DONE; add, subtract and multiply pass
// through S_READ and S_WRITE, divide by zero through S_READ, and divide through S_READ,
// S_DIV and S_WRITE. The next item is accepted once the result is in the output register;
// S_DONE waits while the output register holds a result not yet taken.
// Reset empties the stack and clears the halted flag; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one instruction word per item against a memory-held stack and
// returns the top of stack, the halted flag and a status code.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
    import sme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,   // [31:0] instruction_word
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [31:0] top_value, [32] halted, [35:33] status
);

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   instr_reg, instr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   top_reg, top_next;
    logic                halt_reg, halt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]   res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_data_reg, m_data_next;

    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [PTR_W-1:0]    rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic                div_start;
    logic                div_done;
    logic [WORD_W-1:0]   div_quot;
    logic [2*WORD_W-1:0] prod_full;
    logic [BODY_W-1:0]   body;
    logic [PTR_W-1:0]    second_addr;

    sme_stack_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_data),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign body        = instr_reg[BODY_W-1:0];
    assign second_addr = PTR_W'(count_reg - CNT_W'(2));
    assign prod_full   = rd_data * top_reg;
    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        instr_next   = instr_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        halt_next    = halt_reg;
        status_next  = status_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = second_addr;
        wr_data      = res_reg;
        rd_addr      = second_addr;
        div_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    instr_next = s_tdata;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                status_next = ST_OK;
                state_next  = S_DONE;
                // Header bit 30 clear means a push (headers 0 and 2).
                if (halt_reg) begin
                    status_next = ST_IGNORED;
                end else if (!instr_reg[30]) begin
                    if (count_reg == CNT_W'(STACK_DEPTH)) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[PTR_W-1:0];
                        wr_data    = {{(WORD_W-BODY_W){1'b0}}, body};
                        top_next   = {{(WORD_W-BODY_W){1'b0}}, body};
                        count_next = count_reg + 1'b1;
                    end
                end else if (body == PRIM_HALT) begin
                    halt_next = 1'b1;
                end else if (body > PRIM_DIV) begin
                    status_next = ST_OK;
                end else if (count_reg < CNT_W'(2)) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_WRITE;
                priority case (body)
                    PRIM_ADD: res_next = rd_data + top_reg;
                    PRIM_SUB: res_next = rd_data - top_reg;
                    PRIM_MUL: res_next = prod_full[WORD_W-1:0];
                    default: begin
                        if (top_reg == '0) begin
                            status_next = ST_DIVZERO;
                            state_next  = S_DONE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = div_quot;
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                wr_en      = 1'b1;
                top_next   = res_reg;
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(OUT_W-WORD_W-1-STATUS_W){1'b0}}, status_reg, halt_reg,
                                    (count_reg == '0) ? {WORD_W{1'b0}} : top_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            halt_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            halt_reg    <= halt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        instr_reg  <= instr_next;
        top_reg    <= top_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halted flag cleared without reset");

    a_ignored_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg[WORD_W+STATUS_W:WORD_W+1] == ST_IGNORED)
        |-> m_data_reg[WORD_W])
        else $error("ignored status without halted flag");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (top_reg != '0) && (count_reg >= CNT_W'(2)))
        else $error("divider started with zero divisor or short stack");
`endif

endmodule
